// File: hdl/pcl_pkg.sv
// ----------------------------------------------------------------------------
// pcl_pkg
// Shared codes and types of the positional circular list: request codes,
// result status codes, cell operation codes and controller state codes.
// ----------------------------------------------------------------------------
package pcl_pkg;

   localparam int FUNC_W     = 3;
   localparam int POSITION_W = 6;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int LENGTH_W   = 6;
   localparam int CELL_OP_W  = 3;
   localparam int STATE_W    = 1;

   typedef logic [FUNC_W-1:0]         func_type;
   typedef logic [POSITION_W-1:0]     position_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [STATUS_W-1:0]       status_type;
   typedef logic [LENGTH_W-1:0]       length_type;
   typedef logic [CELL_OP_W-1:0]      cell_op_type;
   typedef logic [STATE_W-1:0]        state_type;

   // request codes
   localparam func_type FUNC_PREPEND   = 3'd0;
   localparam func_type FUNC_APPEND    = 3'd1;
   localparam func_type FUNC_INSERT    = 3'd2;
   localparam func_type FUNC_DEL_FIRST = 3'd3;
   localparam func_type FUNC_DEL_LAST  = 3'd4;
   localparam func_type FUNC_DEL_AT    = 3'd5;
   localparam func_type FUNC_TRAVERSE  = 3'd6;

   // result status codes
   localparam status_type STATUS_OK     = 2'd0;
   localparam status_type STATUS_EMPTY  = 2'd1;
   localparam status_type STATUS_FULL   = 2'd2;
   localparam status_type STATUS_BADPOS = 2'd3;

   // cell operations
   localparam cell_op_type CELL_HOLD  = 3'd0;
   localparam cell_op_type CELL_LEFT  = 3'd1;
   localparam cell_op_type CELL_RIGHT = 3'd2;
   localparam cell_op_type CELL_LOAD  = 3'd3;
   localparam cell_op_type CELL_HEAD  = 3'd4;

   // controller states
   localparam state_type ST_IDLE = 1'b0;
   localparam state_type ST_TRAV = 1'b1;

endpackage

// File: hdl/pcl_req_if.sv
// ----------------------------------------------------------------------------
// pcl_req_if
// Request channel of the positional circular list: valid/ready handshake
// with the request code, position and value.
// ----------------------------------------------------------------------------
interface pcl_req_if;
   logic                  valid;
   logic                  ready;
   pcl_pkg::func_type     func;
   pcl_pkg::position_type position;
   pcl_pkg::value_type    in_value;

   modport source (output valid, output func, output position, output in_value,
                   input ready);
   modport sink   (input valid, input func, input position, input in_value,
                   output ready);
endinterface

// File: hdl/pcl_rsp_if.sv
// ----------------------------------------------------------------------------
// pcl_rsp_if
// Result channel of the positional circular list: valid/ready handshake
// with status, value, length, empty flag and last marker.
// ----------------------------------------------------------------------------
interface pcl_rsp_if;
   logic                  valid;
   logic                  ready;
   pcl_pkg::status_type   status;
   pcl_pkg::value_type    out_value;
   pcl_pkg::length_type   list_length;
   logic                  is_empty;
   logic                  last;

   modport source (output valid, output status, output out_value,
                   output list_length, output is_empty, output last,
                   input ready);
   modport sink   (input valid, input status, input out_value,
                   input list_length, input is_empty, input last,
                   output ready);
endinterface

// File: hdl/pcl_cell.sv
// ----------------------------------------------------------------------------
// pcl_cell
// One storage cell of the list chain. Holds one element and each cycle
// keeps it, takes a neighbour's element, loads a new value or takes the
// head element (rotation during traverse).
// ----------------------------------------------------------------------------
module pcl_cell (
   input  logic                 clock,
   input  pcl_pkg::cell_op_type op,
   input  pcl_pkg::value_type   left_data,
   input  pcl_pkg::value_type   right_data,
   input  pcl_pkg::value_type   load_data,
   input  pcl_pkg::value_type   head_data,
   output pcl_pkg::value_type   data
);

   pcl_pkg::value_type data_ff;
   pcl_pkg::value_type data_in;

   always_comb begin
      case (op)
         pcl_pkg::CELL_LEFT:  data_in = left_data;
         pcl_pkg::CELL_RIGHT: data_in = right_data;
         pcl_pkg::CELL_LOAD:  data_in = load_data;
         pcl_pkg::CELL_HEAD:  data_in = head_data;
         default:             data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// File: hdl/positional_circular_list.sv
// ----------------------------------------------------------------------------
// positional_circular_list
// Bounded ordered list of signed 32-bit values kept packed in a chain of
// cells, head in cell 0. Inserts and deletes shift the tail of the chain
// by one cell; traverse rotates the occupied cells once round.
// ----------------------------------------------------------------------------
//
//   channel | dir | payload                                        | handshake
//   --------+-----+------------------------------------------------+----------
//   req     | in  | func, position, in_value                       | valid/ready
//   rsp     | out | status, out_value, list_length, is_empty, last | valid/ready
//
// Every request other than a non-empty traverse gives its result in the
// cycle after the transfer. A non-empty traverse first starts, then gives
// one element per unstalled cycle as the cell chain rotates by one.
// A new request is taken once the previous one is finished and the result
// register is free or being drained in the same cycle.
// Synchronous reset empties the list; cell contents are kept.
// A stalled result holds the result register and pauses the rotation.
// ----------------------------------------------------------------------------
module positional_circular_list #(
   parameter int CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   pcl_req_if.sink     req,
   pcl_rsp_if.source   rsp
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > pcl_pkg::POSITION_W) ? CW : pcl_pkg::POSITION_W;

   pcl_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       trav_ff, trav_in;

   logic                rsp_valid_ff, rsp_valid_in;
   pcl_pkg::status_type rsp_status_ff, rsp_status_in;
   pcl_pkg::value_type  rsp_value_ff, rsp_value_in;
   pcl_pkg::length_type rsp_length_ff, rsp_length_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic                rsp_last_ff, rsp_last_in;

   pcl_pkg::value_type  cell_data [CAPACITY];
   pcl_pkg::cell_op_type cell_op [CAPACITY];

   logic                out_free;
   logic                accept;
   logic                full;
   logic [XW-1:0]       cnt_x;
   logic [XW-1:0]       pos_x;
   logic [XW-1:0]       sel_idx;
   logic                do_ins, do_del, do_rot, emit, start_trav, trav_last;
   pcl_pkg::status_type st;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == pcl_pkg::ST_IDLE) && out_free;
   assign accept    = req.valid && req.ready;
   assign full      = (count_ff == CW'(CAPACITY));
   assign cnt_x     = XW'(count_ff);
   assign pos_x     = XW'(req.position);
   assign do_rot    = (state_ff == pcl_pkg::ST_TRAV) && out_free;
   assign trav_last = (trav_ff == count_ff - CW'(1));

   // decode the request
   always_comb begin
      st         = pcl_pkg::STATUS_OK;
      count_in   = count_ff;
      do_ins     = 1'b0;
      do_del     = 1'b0;
      sel_idx    = '0;
      emit       = 1'b0;
      start_trav = 1'b0;
      if (accept) begin
         emit = 1'b1;
         case (req.func)
            pcl_pkg::FUNC_PREPEND: begin
               if (full) st = pcl_pkg::STATUS_FULL;
               else do_ins = 1'b1;
            end
            pcl_pkg::FUNC_APPEND: begin
               sel_idx = cnt_x;
               if (full) st = pcl_pkg::STATUS_FULL;
               else do_ins = 1'b1;
            end
            pcl_pkg::FUNC_INSERT: begin
               sel_idx = (pos_x - XW'(1) > cnt_x) ? cnt_x : pos_x - XW'(1);
               if (req.position == '0) st = pcl_pkg::STATUS_BADPOS;
               else if (full) st = pcl_pkg::STATUS_FULL;
               else do_ins = 1'b1;
            end
            pcl_pkg::FUNC_DEL_FIRST: begin
               if (count_ff == '0) st = pcl_pkg::STATUS_EMPTY;
               else do_del = 1'b1;
            end
            pcl_pkg::FUNC_DEL_LAST: begin
               sel_idx = cnt_x - XW'(1);
               if (count_ff == '0) st = pcl_pkg::STATUS_EMPTY;
               else do_del = 1'b1;
            end
            pcl_pkg::FUNC_DEL_AT: begin
               sel_idx = pos_x - XW'(1);
               if (req.position == '0) st = pcl_pkg::STATUS_BADPOS;
               else if (count_ff == '0) st = pcl_pkg::STATUS_EMPTY;
               else if (pos_x > cnt_x) st = pcl_pkg::STATUS_BADPOS;
               else do_del = 1'b1;
            end
            pcl_pkg::FUNC_TRAVERSE: begin
               if (count_ff == '0) begin
                  st = pcl_pkg::STATUS_EMPTY;
               end else begin
                  emit       = 1'b0;
                  start_trav = 1'b1;
               end
            end
            default: begin
               st = pcl_pkg::STATUS_OK;
            end
         endcase
         if (do_ins) count_in = count_ff + CW'(1);
         if (do_del) count_in = count_ff - CW'(1);
      end
   end

   // cell chain
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      localparam logic [XW-1:0] IDX = XW'(g);
      pcl_pkg::value_type left_data;
      pcl_pkg::value_type right_data;

      if (g == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_left
         assign left_data = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign right_data = '0;
      end else begin : g_right
         assign right_data = cell_data[g+1];
      end

      always_comb begin
         cell_op[g] = pcl_pkg::CELL_HOLD;
         if (do_ins) begin
            if (IDX > sel_idx) cell_op[g] = pcl_pkg::CELL_LEFT;
            else if (IDX == sel_idx) cell_op[g] = pcl_pkg::CELL_LOAD;
         end else if (do_del) begin
            if (IDX >= sel_idx) cell_op[g] = pcl_pkg::CELL_RIGHT;
         end else if (do_rot) begin
            // last occupied cell takes the head, the rest move one towards it
            if (IDX == cnt_x - XW'(1)) cell_op[g] = pcl_pkg::CELL_HEAD;
            else cell_op[g] = pcl_pkg::CELL_RIGHT;
         end
      end

      pcl_cell u_cell (
         .clock      (clock),
         .op         (cell_op[g]),
         .left_data  (left_data),
         .right_data (right_data),
         .load_data  (req.in_value),
         .head_data  (cell_data[0]),
         .data       (cell_data[g])
      );
   end

   // traverse sequencing
   always_comb begin
      state_in = state_ff;
      trav_in  = trav_ff;
      if (start_trav) begin
         state_in = pcl_pkg::ST_TRAV;
         trav_in  = '0;
      end else if (do_rot) begin
         trav_in = trav_ff + CW'(1);
         if (trav_last) state_in = pcl_pkg::ST_IDLE;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_length_in = rsp_length_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = st;
         rsp_value_in  = '0;
         rsp_length_in = pcl_pkg::length_type'(count_in);
         rsp_empty_in  = (count_in == '0);
         rsp_last_in   = 1'b1;
      end else if (do_rot) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pcl_pkg::STATUS_OK;
         rsp_value_in  = cell_data[0];
         rsp_length_in = pcl_pkg::length_type'(count_ff);
         rsp_empty_in  = 1'b0;
         rsp_last_in   = trav_last;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcl_pkg::ST_IDLE;
         count_ff     <= '0;
         trav_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         trav_ff      <= trav_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_length_ff <= rsp_length_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.out_value   = rsp_value_ff;
   assign rsp.list_length = rsp_length_ff;
   assign rsp.is_empty    = rsp_empty_ff;
   assign rsp.last        = rsp_last_ff;

endmodule

// File: hdl/pcl_checker.sv
// ----------------------------------------------------------------------------
// pcl_checker
// Port-level checks of the positional circular list, bound to the top level.
// ----------------------------------------------------------------------------
module pcl_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input pcl_pkg::status_type rsp_status,
   input pcl_pkg::value_type  rsp_out_value,
   input pcl_pkg::length_type rsp_list_length,
   input logic                rsp_is_empty,
   input logic                rsp_last
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_value)
         && $stable(rsp_status) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_list_length == '0)
      else $error("empty flag with nonzero length");

   // only traverse gives more than one transfer, and those are all ok
   a_mid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == pcl_pkg::STATUS_OK)
      else $error("non-final result without ok status");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == pcl_pkg::STATUS_EMPTY |-> rsp_is_empty)
      else $error("empty status on a non-empty list");

   a_value_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_value != '0 |-> rsp_status == pcl_pkg::STATUS_OK
         && !rsp_is_empty)
      else $error("element value on a failed request");

endmodule

bind positional_circular_list pcl_checker u_pcl_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_status      (rsp.status),
   .rsp_out_value   (rsp.out_value),
   .rsp_list_length (rsp.list_length),
   .rsp_is_empty    (rsp.is_empty),
   .rsp_last        (rsp.last)
);
